// File: rtl/gce_pkg.sv
package gce_pkg;

   localparam int PIX_W          = 8;
   localparam int COLOR_W        = 32;
   localparam int CHAN_W         = 8;
   localparam int NUM_CHAN       = COLOR_W / CHAN_W;
   localparam int D2_W           = 16;
   localparam int LIN_T_W        = 16;
   localparam int T_W            = 17;
   localparam int SQRT_W         = 36;
   localparam int SQRT_TOP       = 34;
   localparam int SQRT_STAGES    = 6;
   localparam int SQRT_PER_STAGE = 3;
   localparam int PROD_W         = CHAN_W + T_W;
   localparam int SUM_W          = PROD_W + 1;
   localparam int FRAC_W         = 16;

   localparam logic [T_W-1:0]   T_ONE       = T_W'(65536);
   localparam logic [D2_W-1:0]  D2_LIMIT    = D2_W'(16384);
   localparam logic [SUM_W-1:0] ROUND_HALF  = SUM_W'(32768);

   localparam logic [1:0] MODE_SOLID  = 2'd0;
   localparam logic [1:0] MODE_LINEAR = 2'd1;
   localparam logic [1:0] MODE_RADIAL = 2'd2;

   localparam logic [1:0] CSR_PAINT_MODE  = 2'd0;
   localparam logic [1:0] CSR_COLOR_START = 2'd1;
   localparam logic [1:0] CSR_COLOR_END   = 2'd2;

   typedef enum logic [1:0] {
      TSEL_START  = 2'd0,
      TSEL_LINEAR = 2'd1,
      TSEL_RADIAL = 2'd2
   } tsel_type;

   // Sideband that rides along the square root stages.
   typedef struct packed {
      tsel_type             tsel;
      logic [LIN_T_W-1:0]   lin_t;
   } side_type;

   typedef struct packed {
      logic [SQRT_W-1:0] rem;
      logic [SQRT_W-1:0] root;
   } sqrt_state_type;

   // One step of the bit-by-bit integer square root.
   function automatic sqrt_state_type sqrt_step(input sqrt_state_type st,
                                                input logic [SQRT_W-1:0] bitv);
      sqrt_state_type    r;
      logic [SQRT_W-1:0] trial;
      trial = st.root + bitv;
      if (st.rem >= trial) begin
         r.rem  = st.rem - trial;
         r.root = (st.root >> 1) + bitv;
      end else begin
         r.rem  = st.rem;
         r.root = st.root >> 1;
      end
      return r;
   endfunction

endpackage

// File: rtl/gce_sqrt_pipe.sv
module gce_sqrt_pipe (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  gce_pkg::side_type       in_side,
   input  gce_pkg::sqrt_state_type in_state,
   output logic                    out_valid,
   output gce_pkg::side_type       out_side,
   output logic [gce_pkg::T_W-1:0] out_root
);
   import gce_pkg::*;

   logic           vld_ff  [SQRT_STAGES];
   side_type       side_ff [SQRT_STAGES];
   sqrt_state_type st_ff   [SQRT_STAGES];

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      logic           prev_vld;
      side_type       prev_side;
      sqrt_state_type prev_st;
      sqrt_state_type st_in;

      if (s == 0) begin : g_first
         assign prev_vld  = in_valid;
         assign prev_side = in_side;
         assign prev_st   = in_state;
      end else begin : g_next
         assign prev_vld  = vld_ff[s-1];
         assign prev_side = side_ff[s-1];
         assign prev_st   = st_ff[s-1];
      end

      always_comb begin
         st_in = prev_st;
         for (int j = 0; j < SQRT_PER_STAGE; j++) begin
            st_in = sqrt_step(st_in,
               SQRT_W'(1) << (SQRT_TOP - 2 * (s * SQRT_PER_STAGE + j)));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         side_ff[s] <= prev_side;
         st_ff[s]   <= st_in;
      end
   end

   assign out_valid = vld_ff[SQRT_STAGES-1];
   assign out_side  = side_ff[SQRT_STAGES-1];
   assign out_root  = st_ff[SQRT_STAGES-1].root[T_W-1:0];

endmodule

// File: rtl/gce_blend.sv
module gce_blend (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  gce_pkg::side_type           in_side,
   input  logic [gce_pkg::T_W-1:0]     in_root,
   input  logic [gce_pkg::COLOR_W-1:0] color_start,
   input  logic [gce_pkg::COLOR_W-1:0] color_end,
   output logic                        out_valid,
   output logic [gce_pkg::COLOR_W-1:0] out_color
);
   import gce_pkg::*;

   logic [T_W-1:0]    t_sel;
   logic [T_W-1:0]    t_inv;
   logic [PROD_W-1:0] ps_in [NUM_CHAN];
   logic [PROD_W-1:0] pe_in [NUM_CHAN];
   logic [PROD_W-1:0] ps_ff [NUM_CHAN];
   logic [PROD_W-1:0] pe_ff [NUM_CHAN];
   logic              prod_vld_ff;
   logic [SUM_W-1:0]  sum   [NUM_CHAN];
   logic [COLOR_W-1:0] color_in;
   logic [COLOR_W-1:0] color_ff;
   logic              out_vld_ff;

   // The start color falls out of the blend with t at zero.
   always_comb begin
      unique case (in_side.tsel)
         TSEL_LINEAR: t_sel = {1'b0, in_side.lin_t};
         TSEL_RADIAL: t_sel = (in_root > T_ONE) ? T_ONE : in_root;
         default:     t_sel = '0;
      endcase
      t_inv = T_ONE - t_sel;
      for (int c = 0; c < NUM_CHAN; c++) begin
         ps_in[c] = PROD_W'(color_start[c*CHAN_W +: CHAN_W]) * PROD_W'(t_inv);
         pe_in[c] = PROD_W'(color_end[c*CHAN_W +: CHAN_W]) * PROD_W'(t_sel);
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         sum[c] = SUM_W'(ps_ff[c]) + SUM_W'(pe_ff[c]) + ROUND_HALF;
         color_in[c*CHAN_W +: CHAN_W] = sum[c][FRAC_W +: CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         prod_vld_ff <= in_valid;
         out_vld_ff  <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         ps_ff[c] <= ps_in[c];
         pe_ff[c] <= pe_in[c];
      end
      color_ff <= color_in;
   end

   assign out_valid = out_vld_ff;
   assign out_color = color_ff;

endmodule

// File: rtl/gradient_color_eval.sv
// Pipeline: a pixel taken on start appears on rsp_pixel_color, with rsp_valid high,
// after one input stage, six square root stages of three steps each,
// one multiply stage and one sum and round stage.
// Throughput: one pixel per cycle; busy never rises and the receiver cannot stall.
// Reset (synchronous, active high) clears the pipeline valid bits and sets
// paint_mode, color_start and color_end to zero.
module gradient_color_eval (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [gce_pkg::PIX_W-1:0]   req_pixel_x,
   input  logic [gce_pkg::PIX_W-1:0]   req_pixel_y,
   output logic                        rsp_valid,
   output logic [gce_pkg::COLOR_W-1:0] rsp_pixel_color,
   input  logic                        csr_wr_en,
   input  logic [1:0]                  csr_index,
   input  logic [gce_pkg::COLOR_W-1:0] csr_wdata
);
   import gce_pkg::*;

   logic [1:0]         paint_mode_ff;
   logic [COLOR_W-1:0] color_start_ff;
   logic [COLOR_W-1:0] color_end_ff;

   logic signed [PIX_W:0]     dx;
   logic signed [PIX_W:0]     dy;
   logic signed [2*PIX_W+1:0] dx_wide;
   logic signed [2*PIX_W+1:0] dy_wide;
   logic [2*PIX_W+1:0]    dx_sq;
   logic [2*PIX_W+1:0]    dy_sq;
   logic [D2_W-1:0]       d2;
   side_type              side_in;
   sqrt_state_type        st_in;

   logic                  s1_vld_ff;
   side_type              s1_side_ff;
   sqrt_state_type        s1_st_ff;

   logic                  sq_vld;
   side_type              sq_side;
   logic [T_W-1:0]        sq_root;

   always_ff @(posedge clock) begin
      if (reset) begin
         paint_mode_ff  <= MODE_SOLID;
         color_start_ff <= '0;
         color_end_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PAINT_MODE:  paint_mode_ff  <= csr_wdata[1:0];
            CSR_COLOR_START: color_start_ff <= csr_wdata;
            CSR_COLOR_END:   color_end_ff   <= csr_wdata;
            default:         ;
         endcase
      end
   end

   assign busy = 1'b0;

   always_comb begin
      dx      = $signed({1'b0, req_pixel_x}) - $signed((PIX_W+1)'(128));
      dy      = $signed({1'b0, req_pixel_y}) - $signed((PIX_W+1)'(128));
      // Sign-extend first so that the squares are formed at full width.
      dx_wide = (2*PIX_W+2)'(dx);
      dy_wide = (2*PIX_W+2)'(dy);
      dx_sq   = $unsigned(dx_wide * dx_wide);
      dy_sq   = $unsigned(dy_wide * dy_wide);
      d2      = D2_W'(dx_sq) + D2_W'(dy_sq);

      side_in.lin_t = LIN_T_W'({1'b0, req_pixel_x} + {1'b0, req_pixel_y}) << 7;
      unique case (paint_mode_ff)
         MODE_LINEAR: side_in.tsel = TSEL_LINEAR;
         MODE_RADIAL: side_in.tsel = (d2 <= D2_LIMIT) ? TSEL_RADIAL : TSEL_START;
         default:     side_in.tsel = TSEL_START;
      endcase

      // The root of d2 shifted up by 18 is t with 16 fraction bits.
      st_in.rem  = SQRT_W'(d2) << 18;
      st_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_side_ff <= side_in;
      s1_st_ff   <= st_in;
   end

   gce_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_vld_ff),
      .in_side   (s1_side_ff),
      .in_state  (s1_st_ff),
      .out_valid (sq_vld),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   gce_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sq_vld),
      .in_side     (sq_side),
      .in_root     (sq_root),
      .color_start (color_start_ff),
      .color_end   (color_end_ff),
      .out_valid   (rsp_valid),
      .out_color   (rsp_pixel_color)
   );

endmodule
